[src/xml_lex_pkg.sv]
package xml_lex_pkg;

  localparam int TOKEN_MAX = 16;
  localparam int NAME_MAX = (TOKEN_MAX < 16) ? TOKEN_MAX : 16;
  localparam int TLEN_W = $clog2(TOKEN_MAX + 1);
  localparam int TIDX_W = $clog2(TOKEN_MAX);
  localparam int QDEPTH = 2;

  typedef enum logic [4:0] {
    S_TEXT, S_OPEN, S_FIRST, S_SKIPSP, S_NAME, S_ATTR, S_SLASH, S_PI, S_PIQ,
    S_BANG, S_BANGD, S_COM, S_COMD1, S_COMD2
  } lex_state_t;

  typedef enum logic [2:0] {
    K_TEXT    = 3'd0,
    K_TEXTEND = 3'd1,
    K_NAME    = 3'd2,
    K_ERROR   = 3'd3,
    K_OK      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    TS_START  = 2'd0,
    TS_TEXT   = 2'd1,
    TS_ENTITY = 2'd2
  } text_sub_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  out_byte;
    logic        is_closing_tag;
    logic        is_self_closing;
    logic        last_of_run;
    logic [15:0] line_number;
  } out_item_t;

  // command from the front lexer to the back emitter
  typedef struct packed {
    logic        single;     // emit one result (res)
    logic        pair;       // also emit a second result after res (doc ok)
    logic        name_run;   // emit the buffered name
    logic [TLEN_W-1:0] name_len;
    logic        closing;
    logic        self_cl;
    logic [2:0]  kind;
    logic [7:0]  byte_v;
    logic [15:0] line;
  } cmd_t;

endpackage

[src/xml_lex_ram.sv]
module xml_lex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/xml_lex_front.sv]
module xml_lex_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 trim,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xml_lex_pkg::in_item_t in_data,
  // token buffer write side
  output logic                 tb_we,
  output logic [xml_lex_pkg::TIDX_W-1:0] tb_waddr,
  output logic [7:0]           tb_wdata,
  // command queue write side
  output logic                 q_push,
  output xml_lex_pkg::cmd_t    q_cmd,
  input  logic                 q_full,
  input  logic                 name_busy
);
  localparam int TW = xml_lex_pkg::TLEN_W;

  xml_lex_pkg::lex_state_t st_r, st_nxt;
  xml_lex_pkg::text_sub_t  sub_r, sub_nxt;
  logic          inq_r, inq_nxt, cl_r, cl_nxt, err_r, err_nxt;
  logic [TW-1:0] len_r, len_nxt;
  logic [15:0]   line_r, line_nxt;
  // entity shadow: entity names are compared from a small register copy
  logic [7:0]    ent_r [6];
  logic          acc;
  logic [7:0]    c;
  logic [15:0]   ln;
  logic          sp, al, dg, do_app, name_ok;
  logic [TW-1:0] app_lim;
  xml_lex_pkg::cmd_t cmd;
  logic          emit_one;
  logic [7:0]    ent_b;

  // a name run blocks further input until it is drained by the back end
  assign in_stall = q_full || name_busy;
  assign acc = in_valid && !in_stall;
  assign c = in_data.data_byte;
  assign sp = (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h20);
  assign al = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  assign dg = (c >= 8'h30 && c <= 8'h39);
  assign ln = (!in_data.mode && c == 8'h0A && line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;

  function automatic logic ent_is(input logic [7:0] e [6], input logic [TW-1:0] n,
                                  input logic [47:0] s, input int k);
    logic m;
    m = (n == TW'(k));
    for (int i = 0; i < 6; i++) begin
      if (i < k && e[i] != s[47-8*i -: 8]) m = 1'b0;
    end
    return m;
  endfunction

  always_comb begin
    st_nxt = st_r; sub_nxt = sub_r; inq_nxt = inq_r; cl_nxt = cl_r;
    err_nxt = err_r; len_nxt = len_r; line_nxt = line_r;
    cmd = '0; cmd.line = ln; emit_one = 1'b0;
    tb_we = 1'b0; tb_waddr = len_r[xml_lex_pkg::TIDX_W-1:0]; tb_wdata = c;
    do_app = 1'b0; app_lim = TW'(xml_lex_pkg::TOKEN_MAX); name_ok = 1'b0;
    ent_b = 8'd0;
    if (err_r) begin
      cmd.kind = xml_lex_pkg::K_ERROR; emit_one = 1'b1;
    end else if (in_data.mode) begin
      emit_one = 1'b1;
      if (len_r != '0 || st_r != xml_lex_pkg::S_TEXT) begin
        cmd.kind = xml_lex_pkg::K_ERROR; err_nxt = 1'b1;
      end else begin
        cmd.kind = xml_lex_pkg::K_TEXTEND; cmd.pair = 1'b1;
      end
    end else begin
      line_nxt = ln;
      case (st_r)
        xml_lex_pkg::S_TEXT: begin
          if (c == 8'h3C) begin
            st_nxt = xml_lex_pkg::S_OPEN; cmd.kind = xml_lex_pkg::K_TEXTEND;
            emit_one = 1'b1; len_nxt = '0; sub_nxt = xml_lex_pkg::TS_START;
            cl_nxt = 1'b0; inq_nxt = 1'b0;
          end else if (sub_r == xml_lex_pkg::TS_START && sp && trim) begin
          end else if (sub_r != xml_lex_pkg::TS_ENTITY) begin
            sub_nxt = xml_lex_pkg::TS_TEXT;
            if (c == 8'h26) begin
              do_app = 1'b1;
              if (len_r < app_lim) sub_nxt = xml_lex_pkg::TS_ENTITY;
            end else begin
              cmd.kind = xml_lex_pkg::K_TEXT; cmd.byte_v = c; emit_one = 1'b1;
            end
          end else begin
            do_app = 1'b1;
            if (len_r < app_lim && c == 8'h3B) begin
              sub_nxt = xml_lex_pkg::TS_TEXT; len_nxt = '0;
              if (ent_is(ent_r, len_r, {"&lt", 24'h0}, 3)) ent_b = 8'h3C;
              else if (ent_is(ent_r, len_r, {"&gt", 24'h0}, 3)) ent_b = 8'h3E;
              else if (ent_is(ent_r, len_r, {"&apos", 8'h0}, 5)) ent_b = 8'h27;
              else if (ent_is(ent_r, len_r, {"&quot", 8'h0}, 5)) ent_b = 8'h22;
              else if (ent_is(ent_r, len_r, {"&amp", 16'h0}, 4)) ent_b = 8'h26;
              if (ent_b != 8'd0) begin
                cmd.kind = xml_lex_pkg::K_TEXT; cmd.byte_v = ent_b; emit_one = 1'b1;
              end
            end
          end
        end
        xml_lex_pkg::S_OPEN, xml_lex_pkg::S_FIRST: begin
          if (st_r == xml_lex_pkg::S_OPEN && c == 8'h2F) begin
            st_nxt = xml_lex_pkg::S_SKIPSP; cl_nxt = 1'b1;
          end else if (st_r == xml_lex_pkg::S_OPEN && c == 8'h3F) begin
            st_nxt = xml_lex_pkg::S_PI;
          end else if (st_r == xml_lex_pkg::S_OPEN && c == 8'h21) begin
            st_nxt = xml_lex_pkg::S_BANG;
          end else begin
            st_nxt = xml_lex_pkg::S_FIRST;
            if (!sp) begin
              if (al) begin
                do_app = 1'b1; app_lim = TW'(xml_lex_pkg::NAME_MAX);
                if (len_r < app_lim) st_nxt = xml_lex_pkg::S_NAME;
              end else begin
                err_nxt = 1'b1; cmd.kind = xml_lex_pkg::K_ERROR; emit_one = 1'b1;
              end
            end
          end
        end
        xml_lex_pkg::S_SKIPSP, xml_lex_pkg::S_NAME: begin
          if (st_r == xml_lex_pkg::S_SKIPSP && sp) begin
          end else begin
            st_nxt = xml_lex_pkg::S_NAME;
            if (c == 8'h3A) len_nxt = '0;
            else if (sp) begin
              name_ok = 1'b1; st_nxt = xml_lex_pkg::S_ATTR;
            end else if (al || dg || c == 8'h5F || c == 8'h2D) begin
              do_app = 1'b1; app_lim = TW'(xml_lex_pkg::NAME_MAX);
            end else if (c == 8'h2F) st_nxt = xml_lex_pkg::S_SLASH;
            else if (c == 8'h3E) begin
              name_ok = 1'b1; st_nxt = xml_lex_pkg::S_TEXT;
            end else begin
              err_nxt = 1'b1; cmd.kind = xml_lex_pkg::K_ERROR; emit_one = 1'b1;
            end
          end
        end
        xml_lex_pkg::S_ATTR: begin
          if (inq_r) begin
            if (c == 8'h22) inq_nxt = 1'b0;
          end else if (c == 8'h22) inq_nxt = 1'b1;
          else if (c == 8'h2F) st_nxt = xml_lex_pkg::S_SLASH;
          else if (c == 8'h3E) st_nxt = xml_lex_pkg::S_TEXT;
        end
        xml_lex_pkg::S_SLASH: begin
          if (c != 8'h3E) begin
            err_nxt = 1'b1; cmd.kind = xml_lex_pkg::K_ERROR; emit_one = 1'b1;
          end else begin
            name_ok = 1'b1; cmd.self_cl = 1'b1; st_nxt = xml_lex_pkg::S_TEXT;
          end
        end
        xml_lex_pkg::S_PI: if (c == 8'h3F) st_nxt = xml_lex_pkg::S_PIQ;
        xml_lex_pkg::S_PIQ: begin
          if (c == 8'h3E) st_nxt = xml_lex_pkg::S_TEXT;
          else if (c != 8'h3F) st_nxt = xml_lex_pkg::S_PI;
        end
        xml_lex_pkg::S_BANG, xml_lex_pkg::S_BANGD: begin
          if (c == 8'h2D) begin
            st_nxt = (st_r == xml_lex_pkg::S_BANG) ? xml_lex_pkg::S_BANGD
                                                  : xml_lex_pkg::S_COM;
          end else begin
            err_nxt = 1'b1; cmd.kind = xml_lex_pkg::K_ERROR; emit_one = 1'b1;
          end
        end
        xml_lex_pkg::S_COM: if (c == 8'h2D) st_nxt = xml_lex_pkg::S_COMD1;
        xml_lex_pkg::S_COMD1:
          st_nxt = (c == 8'h2D) ? xml_lex_pkg::S_COMD2 : xml_lex_pkg::S_COM;
        xml_lex_pkg::S_COMD2: begin
          if (c == 8'h3E) st_nxt = xml_lex_pkg::S_TEXT;
          else if (c != 8'h2D) st_nxt = xml_lex_pkg::S_COM;
        end
        default: begin
          err_nxt = 1'b1; cmd.kind = xml_lex_pkg::K_ERROR; emit_one = 1'b1;
        end
      endcase
      if (do_app) begin
        if (len_r < app_lim) begin
          tb_we = 1'b1;
          if (!(sub_r == xml_lex_pkg::TS_ENTITY && st_r == xml_lex_pkg::S_TEXT
                && c == 8'h3B)) len_nxt = len_r + TW'(1);
        end else begin
          err_nxt = 1'b1; cmd.kind = xml_lex_pkg::K_ERROR; emit_one = 1'b1;
        end
      end
      if (name_ok) begin
        len_nxt = '0;
        if (len_r != '0) begin
          cmd.name_run = 1'b1; cmd.name_len = len_r; cmd.closing = cl_r;
          cmd.kind = xml_lex_pkg::K_NAME;
        end
      end
    end
    cmd.single = emit_one;
  end

  assign q_cmd = cmd;
  assign q_push = acc && (cmd.single || cmd.name_run);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= xml_lex_pkg::S_TEXT; sub_r <= xml_lex_pkg::TS_START;
      inq_r <= 1'b0; cl_r <= 1'b0; err_r <= 1'b0; len_r <= '0; line_r <= '0;
    end else if (acc) begin
      st_r <= st_nxt; sub_r <= sub_nxt; inq_r <= inq_nxt; cl_r <= cl_nxt;
      err_r <= err_nxt; len_r <= len_nxt; line_r <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && tb_we && len_r < TW'(6)) ent_r[len_r[2:0]] <= c;
  end

`ifndef SYNTHESIS
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= TW'(xml_lex_pkg::TOKEN_MAX))
    else $error("token length overflow");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error latch cleared");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");
`endif
endmodule

[src/xml_lex_back.sv]
module xml_lex_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  xml_lex_pkg::cmd_t    q_cmd,
  output logic                 q_pop,
  output logic                 name_busy,
  output logic [xml_lex_pkg::TIDX_W-1:0] tb_raddr,
  input  logic [7:0]           tb_rdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xml_lex_pkg::out_item_t out_data
);
  localparam int TW = xml_lex_pkg::TLEN_W;

  // idx_r: next name byte to read; rd_r: a RAM read is in flight
  logic          run_r, run_nxt, pend_r, pend_nxt;
  logic [TW-1:0] idx_r, idx_nxt;
  logic [TW-1:0] idx_m1;
  logic          ov_r, ov_nxt;
  xml_lex_pkg::out_item_t ob_r, ob_nxt;
  logic          rd_r, rd_nxt;
  logic          free;

  assign free = !ov_r || !out_stall;
  assign name_busy = run_r || (q_valid && q_cmd.name_run);
  // while the output holds, keep re-reading the byte in flight
  assign idx_m1 = idx_r - TW'(1);
  assign tb_raddr = (run_r && rd_r && !free) ? idx_m1[xml_lex_pkg::TIDX_W-1:0]
                                              : idx_r[xml_lex_pkg::TIDX_W-1:0];
  assign out_valid = ov_r;
  assign out_data = ob_r;

  always_comb begin
    run_nxt = run_r; pend_nxt = pend_r; idx_nxt = idx_r; ov_nxt = ov_r;
    ob_nxt = ob_r; rd_nxt = 1'b0; q_pop = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (run_r) begin
      if (rd_r && free) begin
        ov_nxt = 1'b1;
        ob_nxt = '{q_cmd.kind, tb_rdata, q_cmd.closing, q_cmd.self_cl,
                   (idx_r == q_cmd.name_len), q_cmd.line};
        if (idx_r == q_cmd.name_len) begin
          run_nxt = 1'b0; q_pop = 1'b1;
        end
      end
      if (!rd_r || free) begin
        if (idx_r != q_cmd.name_len) begin
          rd_nxt = 1'b1; idx_nxt = idx_r + TW'(1);
        end
      end else rd_nxt = rd_r;
    end else if (q_valid && free) begin
      if (q_cmd.name_run) begin
        run_nxt = 1'b1; idx_nxt = '0;
      end else if (q_cmd.pair && !pend_r) begin
        ov_nxt = 1'b1; pend_nxt = 1'b1;
        ob_nxt = '{q_cmd.kind, 8'd0, 1'b0, 1'b0, 1'b0, q_cmd.line};
      end else if (pend_r) begin
        ov_nxt = 1'b1; pend_nxt = 1'b0; q_pop = 1'b1;
        ob_nxt = '{xml_lex_pkg::K_OK, 8'd0, 1'b0, 1'b0, 1'b1, q_cmd.line};
      end else begin
        ov_nxt = 1'b1; q_pop = 1'b1;
        ob_nxt = '{q_cmd.kind, q_cmd.byte_v, 1'b0, 1'b0, 1'b1, q_cmd.line};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; pend_r <= 1'b0; idx_r <= '0; ov_r <= 1'b0; rd_r <= 1'b0;
    end else begin
      run_r <= run_nxt; pend_r <= pend_nxt; idx_r <= idx_nxt; ov_r <= ov_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ob_r)))
    else $error("stalled result changed");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (idx_r <= q_cmd.name_len))
    else $error("name index past length");
  a_run_q: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> q_valid)
    else $error("name run without queued command");
`endif
endmodule

[src/xml_markup_lexer_unit.sv]
// channel | direction | handshake        | payload
// in_     | input     | valid / stall    | in_item_t  (mode, data_byte)
// out_    | output     | valid / stall    | out_item_t (event, byte, flags, line)
// cfg_    | input     | valid / ready    | trim_leading_space
//
// Results leave the back end at one per cycle while out_stall is low.
// A tag name holds input while the back end reads the token RAM one byte a
// cycle, stalled with the output; document ok adds a second result.
// Synchronous active-low reset; trim resets to 1, no clearing pass.
// Either side may stall; a two-entry command queue decouples them.
module xml_markup_lexer_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  xml_lex_pkg::in_item_t   in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output xml_lex_pkg::out_item_t  out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data
);
  localparam int QD = xml_lex_pkg::QDEPTH;

  logic trim_r;
  logic tb_we;
  logic [xml_lex_pkg::TIDX_W-1:0] tb_waddr, tb_raddr;
  logic [7:0] tb_wdata, tb_rdata;
  logic q_push, q_pop, name_busy, q_full, q_valid;
  xml_lex_pkg::cmd_t push_cmd;
  // command queue: tiny register FIFO
  xml_lex_pkg::cmd_t q_mem_r [QD];
  logic [$clog2(QD)-1:0] wp_r, rp_r;
  logic [$clog2(QD):0]   cnt_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) trim_r <= 1'b1;
    else if (cfg_valid) trim_r <= cfg_data;
  end

  xml_lex_front u_front (
    .clk, .rst_n, .trim(trim_r), .in_valid, .in_stall, .in_data,
    .tb_we, .tb_waddr, .tb_wdata, .q_push, .q_cmd(push_cmd), .q_full, .name_busy
  );

  xml_lex_ram #(.WIDTH(8), .DEPTH(xml_lex_pkg::TOKEN_MAX)) u_tok (
    .clk, .we(tb_we && in_valid && !in_stall), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  assign q_full = (cnt_r == ($clog2(QD)+1)'(QD));
  assign q_valid = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (q_push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QD)+1)'(q_push) - ($clog2(QD)+1)'(q_pop);
    end
  end
  always_ff @(posedge clk) begin
    if (q_push) q_mem_r[wp_r] <= push_cmd;
  end

  xml_lex_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd(q_mem_r[rp_r]), .q_pop, .name_busy,
    .tb_raddr, .tb_rdata, .out_valid, .out_stall, .out_data
  );

`ifndef SYNTHESIS
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ($clog2(QD)+1)'(QD))
    else $error("queue count overflow");
  a_name_hold: assert property (@(posedge clk) disable iff (!rst_n)
    name_busy |-> in_stall)
    else $error("input taken during name run");
`endif
endmodule
